// File: rtl/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg
// Shared types, character codes and search patterns of the response parser.
// ----------------------------------------------------------------------------
package atrp_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    // Characters that open, end or shape a line
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UP_O  = 8'h4F;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Event codes
    localparam logic [2:0] EV_OK          = 3'd0;
    localparam logic [2:0] EV_ERROR       = 3'd1;
    localparam logic [2:0] EV_SEND_OK     = 3'd2;
    localparam logic [2:0] EV_MODULE_OK   = 3'd3;
    localparam logic [2:0] EV_NO_IP       = 3'd4;
    localparam logic [2:0] EV_SEND_PROMPT = 3'd5;

    // Result kinds
    localparam logic RK_PAYLOAD = 1'b0;
    localparam logic RK_EVENT   = 1'b1;

    // Search patterns, right aligned
    localparam logic [71:0] STR_OK        = "OK";
    localparam logic [71:0] STR_ERROR     = "ERROR";
    localparam logic [71:0] STR_SEND_OK   = "SEND OK";
    localparam logic [71:0] STR_MODULE_OK = "module ok";
    localparam logic [71:0] STR_NO_IP     = "no ip";
    localparam logic [71:0] STR_IPD       = "+IPD,";
    localparam int          IPD_HEAD_LEN  = 5;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TERM,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        PAT_NONE,
        PAT_OK,
        PAT_ERROR,
        PAT_SEND_OK,
        PAT_MODULE_OK,
        PAT_NO_IP,
        PAT_IPD
    } pat_sel_t;

    typedef enum logic [1:0] {
        NUM_WS,
        NUM_SIGN,
        NUM_DIG,
        NUM_DONE
    } num_st_t;

    // Controller to datapath
    typedef struct packed {
        logic       line_start;  // head byte: open a new line
        logic       line_byte;   // byte inside a line
        logic       pay_load;    // start a payload frame
        logic       pay_step;    // pass one payload byte
        logic       ev_emit;     // load an event result
        logic [2:0] ev_code;
    } atrp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       hit_now;     // pattern seen, current byte included
        logic       line_evt;    // line pattern yields an event
        logic [2:0] line_code;
        logic       ipd_ok;      // frame length is positive
        logic       pay_last;    // current payload byte ends the frame
    } atrp_stat_t;

    function automatic logic [7:0] str_at(logic [71:0] s, logic [3:0] n, logic [3:0] i);
        int k;
        logic [7:0] c;
        c = CH_NUL;
        k = 8 * (int'(n) - 1 - int'(i));
        if (i < n)
        begin
            c = s[k +: 8];
        end
        return c;
    endfunction

    function automatic logic [3:0] pat_len(pat_sel_t sel);
        logic [3:0] n;
        unique case (sel)
            PAT_OK:        n = 4'd2;
            PAT_ERROR:     n = 4'd5;
            PAT_SEND_OK:   n = 4'd7;
            PAT_MODULE_OK: n = 4'd9;
            PAT_NO_IP:     n = 4'd5;
            PAT_IPD:       n = 4'd5;
            default:       n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pat_char(pat_sel_t sel, logic [3:0] i);
        logic [7:0] c;
        unique case (sel)
            PAT_OK:        c = str_at(STR_OK, pat_len(sel), i);
            PAT_ERROR:     c = str_at(STR_ERROR, pat_len(sel), i);
            PAT_SEND_OK:   c = str_at(STR_SEND_OK, pat_len(sel), i);
            PAT_MODULE_OK: c = str_at(STR_MODULE_OK, pat_len(sel), i);
            PAT_NO_IP:     c = str_at(STR_NO_IP, pat_len(sel), i);
            PAT_IPD:       c = str_at(STR_IPD, pat_len(sel), i);
            default:       c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/atrp_ctrl.sv
// ----------------------------------------------------------------------------
// atrp_ctrl
// Parse phase state machine: picks terminators and issues datapath commands.
// ----------------------------------------------------------------------------
module atrp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  atrp_pkg::atrp_stat_t stat,
    output atrp_pkg::atrp_cmd_t  cmd
);
    import atrp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] term_reg, term_next;
    logic       is_head;
    logic       at_term;

    always_comb
    begin
        is_head = (rx_byte == CH_PLUS) || (rx_byte == CH_UP_O) || (rx_byte == CH_UP_E)
               || (rx_byte == CH_UP_S) || (rx_byte == CH_LO_M) || (rx_byte == CH_LO_N)
               || (rx_byte == CH_UP_R) || (rx_byte == CH_GT);
        at_term = (rx_byte == term_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            term_reg  <= CH_NUL;
        end
        else
        begin
            phase_reg <= phase_next;
            term_reg  <= term_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        term_next  = term_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TERM:
                begin
                    if (at_term)
                    begin
                        priority if (term_reg == CH_COMMA)
                        begin
                            term_next = stat.hit_now ? CH_COLON : CH_LF;
                        end
                        else if (term_reg == CH_COLON && stat.ipd_ok)
                        begin
                            phase_next = PH_DATA;
                            term_next  = CH_NUL;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                            term_next  = CH_NUL;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (stat.pay_last)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    if (is_head)
                    begin
                        phase_next = PH_TERM;
                        priority if (rx_byte == CH_PLUS)
                        begin
                            term_next = CH_COMMA;
                        end
                        else if (rx_byte == CH_GT)
                        begin
                            term_next = CH_SPACE;
                        end
                        else
                        begin
                            term_next = CH_LF;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TERM:
                begin
                    cmd.line_byte = 1'b1;
                    if (at_term)
                    begin
                        priority if (term_reg == CH_COLON)
                        begin
                            cmd.pay_load = stat.ipd_ok;
                        end
                        else if (term_reg == CH_LF)
                        begin
                            cmd.ev_emit = stat.hit_now && stat.line_evt;
                            cmd.ev_code = stat.line_code;
                        end
                        else if (term_reg == CH_SPACE)
                        begin
                            cmd.ev_emit = 1'b1;
                            cmd.ev_code = EV_SEND_PROMPT;
                        end
                        else
                        begin
                            cmd.ev_emit = 1'b0;
                        end
                    end
                end
                PH_DATA:
                begin
                    cmd.pay_step = 1'b1;
                end
                default:
                begin
                    cmd.line_start = is_head;
                end
            endcase
        end
    end

endmodule

// File: rtl/atrp_dp.sv
// ----------------------------------------------------------------------------
// atrp_dp
// Line datapath: fill count, pattern matcher, length parser, payload counter
// and the result register.
// ----------------------------------------------------------------------------
module atrp_dp
#(
    parameter int LINE_DEPTH = atrp_pkg::LINE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  atrp_pkg::atrp_cmd_t  cmd,
    output atrp_pkg::atrp_stat_t stat,
    output logic                 result_kind,
    output logic [7:0]           payload_byte,
    output logic                 payload_last,
    output logic [2:0]           event_code
);
    import atrp_pkg::*;

    localparam int LEN_W = $clog2(LINE_DEPTH + 1);

    logic [LEN_W-1:0] len_reg, len_next;
    pat_sel_t         sel_reg, sel_next;
    logic [3:0]       mpos_reg, mpos_next;
    logic             found_reg, found_next;
    logic             pref_reg, pref_next;
    num_st_t          num_reg, num_next;
    logic             neg_reg, neg_next;
    logic             dig_reg, dig_next;
    logic [15:0]      mag_reg, mag_next;
    logic [15:0]      rem_reg, rem_next;

    logic             stored;
    logic             is_digit;
    logic             is_ws;
    logic [19:0]      acc;
    logic [15:0]      acc_sat;
    logic             adv;

    always_comb
    begin
        stored   = (len_reg < LEN_W'(LINE_DEPTH));
        is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= 8'd9) && (rx_byte <= 8'd13));
        acc      = {mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {12'd0, rx_byte - CH_ZERO};
        acc_sat  = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
        adv      = (sel_reg != PAT_NONE) && (rx_byte == pat_char(sel_reg, mpos_reg));
    end

    // Status
    always_comb
    begin
        stat.hit_now   = found_reg
                      || (stored && adv && ((mpos_reg + 4'd1) == pat_len(sel_reg)));
        stat.line_evt  = (sel_reg != PAT_NONE) && (sel_reg != PAT_IPD);
        unique case (sel_reg)
            PAT_ERROR:     stat.line_code = EV_ERROR;
            PAT_SEND_OK:   stat.line_code = EV_SEND_OK;
            PAT_MODULE_OK: stat.line_code = EV_MODULE_OK;
            PAT_NO_IP:     stat.line_code = EV_NO_IP;
            default:       stat.line_code = EV_OK;
        endcase
        stat.ipd_ok    = pref_reg && dig_reg && !neg_reg && (mag_reg != 16'd0);
        stat.pay_last  = (rem_reg == 16'd1);
    end

    always_comb
    begin
        len_next   = len_reg;
        sel_next   = sel_reg;
        mpos_next  = mpos_reg;
        found_next = found_reg;
        pref_next  = pref_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;

        if (cmd.line_start)
        begin
            // The head byte is always the first character of its pattern
            unique case (rx_byte)
                CH_PLUS: sel_next = PAT_IPD;
                CH_UP_O: sel_next = PAT_OK;
                CH_UP_E: sel_next = PAT_ERROR;
                CH_UP_S: sel_next = PAT_SEND_OK;
                CH_LO_M: sel_next = PAT_MODULE_OK;
                CH_LO_N: sel_next = PAT_NO_IP;
                default: sel_next = PAT_NONE;
            endcase
            len_next   = LEN_W'(1);
            mpos_next  = (sel_next == PAT_NONE) ? 4'd0 : 4'd1;
            found_next = 1'b0;
            pref_next  = (rx_byte == CH_PLUS);
            num_next   = NUM_WS;
            neg_next   = 1'b0;
            dig_next   = 1'b0;
            mag_next   = 16'd0;
        end
        else if (cmd.line_byte && stored)
        begin
            len_next = len_reg + LEN_W'(1);
            // Matcher: no pattern repeats its first character
            if (!found_reg)
            begin
                if (adv)
                begin
                    mpos_next  = mpos_reg + 4'd1;
                    found_next = (mpos_next == pat_len(sel_reg));
                end
                else
                begin
                    mpos_next = ((sel_reg != PAT_NONE) && (rx_byte == pat_char(sel_reg, 4'd0)))
                              ? 4'd1 : 4'd0;
                end
            end
            if (len_reg < LEN_W'(IPD_HEAD_LEN))
            begin
                pref_next = pref_reg && (rx_byte == pat_char(PAT_IPD, len_reg[3:0]));
            end
            else if (pref_reg)
            begin
                unique case (num_reg)
                    NUM_WS:
                    begin
                        priority if (is_ws)
                        begin
                            num_next = NUM_WS;
                        end
                        else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                        begin
                            neg_next = (rx_byte == CH_MINUS);
                            num_next = NUM_SIGN;
                        end
                        else if (is_digit)
                        begin
                            mag_next = acc_sat;
                            dig_next = 1'b1;
                            num_next = NUM_DIG;
                        end
                        else
                        begin
                            num_next = NUM_DONE;
                        end
                    end
                    NUM_SIGN, NUM_DIG:
                    begin
                        if (is_digit)
                        begin
                            mag_next = acc_sat;
                            dig_next = 1'b1;
                            num_next = NUM_DIG;
                        end
                        else
                        begin
                            num_next = NUM_DONE;
                        end
                    end
                    default:
                    begin
                        num_next = NUM_DONE;
                    end
                endcase
            end
        end

        if (cmd.pay_load)
        begin
            rem_next = mag_reg;
        end
        else if (cmd.pay_step)
        begin
            rem_next = rem_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            sel_reg   <= PAT_NONE;
            mpos_reg  <= 4'd0;
            found_reg <= 1'b0;
            pref_reg  <= 1'b0;
            num_reg   <= NUM_DONE;
            neg_reg   <= 1'b0;
            dig_reg   <= 1'b0;
            mag_reg   <= 16'd0;
            rem_reg   <= 16'd0;
        end
        else
        begin
            len_reg   <= len_next;
            sel_reg   <= sel_next;
            mpos_reg  <= mpos_next;
            found_reg <= found_next;
            pref_reg  <= pref_next;
            num_reg   <= num_next;
            neg_reg   <= neg_next;
            dig_reg   <= dig_next;
            mag_reg   <= mag_next;
            rem_reg   <= rem_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.ev_emit)
        begin
            result_kind  <= RK_EVENT;
            payload_byte <= 8'd0;
            payload_last <= 1'b0;
            event_code   <= cmd.ev_code;
        end
        else if (cmd.pay_step)
        begin
            result_kind  <= RK_PAYLOAD;
            payload_byte <= rx_byte;
            payload_last <= stat.pay_last;
            event_code   <= EV_OK;
        end
    end

endmodule

// File: rtl/at_response_line_parser_core.sv
// ----------------------------------------------------------------------------
// at_response_line_parser_core
// Modem response parser: spots response lines and passes IPD payload through.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears on the master side in the cycle
//   after the byte that causes it is taken.
// Throughput: one byte per cycle while the result register drains; every
//   byte is parsed in a single step of the line datapath, no memory sweep.
// Reset: rst_n clears the phase, terminator, counters and the result valid;
//   the block takes bytes as soon as reset is released.
module at_response_line_parser_core
#(
    parameter int LINE_DEPTH = atrp_pkg::LINE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] event_code, rest zero
    output logic        m_tlast,   // payload_last
    output logic        m_tuser    // result_kind
);
    import atrp_pkg::*;

    atrp_cmd_t  cmd;
    atrp_stat_t stat;
    logic       s_accept;
    logic       emit;
    logic       out_valid_reg, out_valid_next;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic [2:0] event_code;

    // Take a byte whenever the result register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign emit     = cmd.ev_emit || cmd.pay_step;

    atrp_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (s_accept),
        .rx_byte (s_tdata),
        .stat    (stat),
        .cmd     (cmd)
    );

    atrp_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (s_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .payload_last (payload_last),
        .event_code   (event_code)
    );

    // Hold the result until the sink takes it
    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, event_code, payload_byte};
    assign m_tlast  = payload_last;
    assign m_tuser  = result_kind;

`ifndef SYNTHESIS
    // One result kind per byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ev_emit && cmd.pay_step))
        else $error("event and payload loaded together");

    // Commands only for a taken byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.line_start || cmd.line_byte || cmd.pay_step || cmd.ev_emit) |-> s_accept)
        else $error("command without an accepted byte");

    // Stall only behind a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result register");

    // A new result lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("loaded result not presented");

    // Frame end marks only payload bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == RK_PAYLOAD))
        else $error("last flag on an event result");
`endif

endmodule
